// ----- design/name_hash_serial_generator_defines.svh -----
// Assertion helpers for the block that checks itself.
`ifndef NAME_HASH_SERIAL_GENERATOR_DEFINES_SVH
`define NAME_HASH_SERIAL_GENERATOR_DEFINES_SVH

// Same-cycle implication, quiet during reset.
`define NHSG_ASSERT_NOW(label, clk_s, rstn_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, quiet during reset.
`define NHSG_ASSERT_NEXT(label, clk_s, rstn_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/nhsg_pkg.sv -----
package nhsg_pkg;

  typedef logic [31:0] acc_t;
  typedef logic [7:0]  pos_t;
  typedef logic [7:0]  byte_t;
  typedef logic [26:0] serial_t;

  localparam acc_t DJB_INIT   = 32'd5381;
  localparam acc_t FNV_INIT   = 32'd2166136261;
  localparam acc_t FNV_PRIME  = 32'd16777619;
  localparam serial_t SERIAL_MOD = 27'd100000000;

  // 100000000 = 256 * 390625; quotient of c[31:8] by 390625 via ceil(2^44 / 390625)
  localparam int RECIP_SHIFT = 44;
  localparam int RECIP_W     = 26;
  localparam logic [RECIP_W-1:0] SERIAL_RECIP = 26'd45035997;

  localparam int QUOT_W = 6;

endpackage

// ----- design/name_hash_serial_generator.sv -----
// A request carrying the end marker passes through stage 1, stage 2 and the result register before its result appears.
// Throughput: one request per cycle while the result register is not stalled; the
// accumulator update (shift-add and one 32-bit constant multiply) is combinational.
// Reset: synchronous, active low; clears the pipeline valids and loads the
// accumulators with their initial values and the position count with zero.
`include "name_hash_serial_generator_defines.svh"

module name_hash_serial_generator (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  nhsg_pkg::byte_t     in_name_byte,
  input  logic                in_byte_present,
  input  logic                in_end_of_name,
  output logic                out_valid,
  input  logic                out_stall,
  output nhsg_pkg::serial_t   out_serial_value
);
  import nhsg_pkg::*;

  localparam int PROD_W = 24 + RECIP_W;

  logic    advance;
  logic    fire;

  acc_t    djb_r, djb_nxt, djb_upd, djb_abs;
  acc_t    fnv_r, fnv_nxt, fnv_upd, fnv_abs;
  pos_t    pos_r, pos_nxt, pos_mul;
  logic [8:0] mix1, mix2;

  logic    s1_valid_r;
  acc_t    s1_djb_r, s1_fnv_r;

  acc_t    c0, c1, c2, c3;
  logic [PROD_W-1:0] prod;
  logic    s2_valid_r;
  acc_t    s2_c_r;
  logic [QUOT_W-1:0] s2_q_r;

  acc_t    q_scaled, rem;
  logic    out_valid_r;
  serial_t out_serial_r;

  // The whole pipeline moves together; hold only when the result register is full and stalled.
  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = !advance;
  assign fire     = in_valid && advance;

  // Per-byte update
  assign pos_mul = pos_r + {pos_r[3:0], 4'b0000};
  assign mix1    = {1'b0, in_name_byte} + {1'b0, pos_r};
  assign mix2    = {1'b0, in_name_byte} + {1'b0, pos_mul};
  assign djb_upd = ({djb_r[26:0], 5'b00000} + djb_r) ^ {23'b0, mix1};
  assign fnv_upd = (fnv_r ^ {23'b0, mix2}) * FNV_PRIME;

  assign djb_abs = in_byte_present ? djb_upd : djb_r;
  assign fnv_abs = in_byte_present ? fnv_upd : fnv_r;

  always_comb begin
    djb_nxt = djb_r;
    fnv_nxt = fnv_r;
    pos_nxt = pos_r;
    if (fire) begin
      if (in_end_of_name) begin
        djb_nxt = DJB_INIT;
        fnv_nxt = FNV_INIT;
        pos_nxt = '0;
      end else if (in_byte_present) begin
        djb_nxt = djb_upd;
        fnv_nxt = fnv_upd;
        pos_nxt = pos_r + 8'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      djb_r <= DJB_INIT;
      fnv_r <= FNV_INIT;
      pos_r <= '0;
    end else begin
      djb_r <= djb_nxt;
      fnv_r <= fnv_nxt;
      pos_r <= pos_nxt;
    end
  end

  // Stage 1: capture the final accumulators of a finished name
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (advance) begin
      s1_valid_r <= fire && in_end_of_name;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_djb_r <= djb_abs;
      s1_fnv_r <= fnv_abs;
    end
  end

  // Stage 2: combine, xorshift, estimate the quotient by 10^8
  assign c0   = s1_djb_r ^ {1'b0, s1_fnv_r[31:1]};
  assign c1   = c0 ^ {c0[18:0], 13'b0};
  assign c2   = c1 ^ {7'b0, c1[31:7]};
  assign c3   = c2 ^ {c2[14:0], 17'b0};
  assign prod = PROD_W'(c3[31:8]) * PROD_W'(SERIAL_RECIP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (advance) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_c_r <= c3;
      s2_q_r <= prod[RECIP_SHIFT +: QUOT_W];
    end
  end

  // Stage 3: remainder into the result register
  assign q_scaled = 32'(s2_q_r) * 32'(SERIAL_MOD);
  assign rem      = s2_c_r - q_scaled;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_serial_r <= rem[26:0];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_serial_value = out_serial_r;

  `NHSG_ASSERT_NOW(a_full_holds_input, clk, rst_n, out_valid && out_stall, in_stall, "input taken while result register is stalled")
  `NHSG_ASSERT_NEXT(a_end_clears_state, clk, rst_n, fire && in_end_of_name, djb_r == DJB_INIT && fnv_r == FNV_INIT && pos_r == '0, "state not cleared after end of name")
  `NHSG_ASSERT_NOW(a_serial_in_range, clk, rst_n, out_valid_r, out_serial_r < SERIAL_MOD, "serial value out of range")
  `NHSG_ASSERT_NEXT(a_stage_reaches_out, clk, rst_n, s2_valid_r && advance, out_valid_r, "result lost between stage 2 and output")

endmodule
